>>> rtl/tdp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_pkg: shared types and constants of the trial division prime test
// Widths of the candidate, the trial divisor and its running square, the
// sequencer states and the status groups passed between the modules.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// Width of a candidate number
	localparam int NUM_W = 16;
	// Trial divisor width: enough for the first divisor whose square exceeds any candidate
	localparam int DIV_W = (NUM_W + 1) / 2 + 1;
	// Width of the running square of the trial divisor
	localparam int SQ_W = 2 * DIV_W;
	// Bit counter of the serial remainder unit
	localparam int CNT_W = $clog2(NUM_W);
	// First trial divisor
	localparam int FIRST_DIV = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} tdp_state_t;

	// Status of the serial remainder unit
	typedef struct packed {
		logic done;
		logic zero;
	} tdp_div_sts_t;

	// Finished test handed to the output register
	typedef struct packed {
		logic valid;
		logic prime;
	} tdp_res_t;

endpackage

`default_nettype wire

>>> rtl/tdp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_in_if / tdp_out_if: request and result channels
// Valid/ready channels; a request or result moves when valid and ready are
// both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface tdp_in_if;
	logic                     valid;
	logic                     ready;
	logic [tdp_pkg::NUM_W-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface tdp_out_if;
	logic                     valid;
	logic                     ready;
	logic [tdp_pkg::NUM_W-1:0] tested_number;
	logic                     is_prime;

	modport source (output valid, output tested_number, output is_prime, input ready);
	modport sink (input valid, input tested_number, input is_prime, output ready);
endinterface

`default_nettype wire

>>> rtl/tdp_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_rem: bit-serial remainder unit
// Restoring division, one dividend bit per cycle shifted in from a shift
// register; reports when the remainder is done and whether it is zero.
// ----------------------------------------------------------------------------
module tdp_rem (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [tdp_pkg::NUM_W-1:0] dividend,
	input  wire logic [tdp_pkg::DIV_W-1:0] divisor,
	output tdp_pkg::tdp_div_sts_t          sts
);
	import tdp_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] shift_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// Bring down the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, shift_q[NUM_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	// Control: count one bit per cycle, pulse done after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the dividend, keep the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[NUM_W-2:0], 1'b0};
			rem_q   <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign sts.done = done_q;
	assign sts.zero = (rem_q == '0);

endmodule

`default_nettype wire

>>> rtl/tdp_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tdp_seq: trial divisor sequencer
// Steps the trial divisor from two while its square stays within the
// candidate, runs one serial remainder per divisor and stops at the first
// zero remainder.
// ----------------------------------------------------------------------------
module tdp_seq (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      req_valid,
	output logic                           req_ready,
	input  wire logic [tdp_pkg::NUM_W-1:0] candidate,
	output tdp_pkg::tdp_res_t              res,
	output logic [tdp_pkg::NUM_W-1:0]      number,
	input  wire logic                      res_ready
);
	import tdp_pkg::*;

	tdp_state_t       state_q;
	tdp_state_t       state_d;
	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] div_q;
	logic [SQ_W-1:0]  sq_q;
	logic             prime_q;
	logic             div_start;
	logic             past_bound;
	tdp_div_sts_t     div_sts;

	assign past_bound = sq_q > SQ_W'(num_q);

	tdp_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_q),
		.divisor  (div_q),
		.sts      (div_sts)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control outputs
	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		res.valid = 1'b0;
		res.prime = prime_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (past_bound) begin
					state_d = ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = div_sts.zero ? ST_DONE : ST_CHECK;
				end
			end
			ST_DONE: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the candidate, advance the divisor and its square, record the verdict
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q <= candidate;
				div_q <= DIV_W'(FIRST_DIV);
				sq_q  <= SQ_W'(FIRST_DIV * FIRST_DIV);
			end
			ST_CHECK: begin
				// Zero and one never reach a divisor and are not prime
				prime_q <= |num_q[NUM_W-1:1];
			end
			ST_DIV: begin
				if (div_sts.done) begin
					if (div_sts.zero) begin
						prime_q <= 1'b0;
					end else begin
						div_q <= div_q + 1'b1;
						sq_q  <= sq_q + SQ_W'({div_q, 1'b1});
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign number = num_q;

endmodule

`default_nettype wire

>>> rtl/trial_division_prime_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Per trial divisor the sequencer checks the square bound, then the bit-serial
//   remainder unit shifts in all NUM_W dividend bits; the test ends at the first
//   divisor that divides or once the divisor's square exceeds the candidate.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: arst_n clears the sequencer to idle and empties the result register.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tdp_in_if.sink     in_ch,
	tdp_out_if.source  out_ch
);
	import tdp_pkg::*;

	tdp_res_t         seq_res;
	logic [NUM_W-1:0] seq_num;
	logic             seq_res_ready;
	logic             out_valid_q;
	logic [NUM_W-1:0] out_num_q;
	logic             out_prime_q;

	tdp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_ch.valid),
		.req_ready (in_ch.ready),
		.candidate (in_ch.candidate),
		.res       (seq_res),
		.number    (seq_num),
		.res_ready (seq_res_ready)
	);

	// Take a finished test when the result register is empty or being drained
	assign seq_res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_res_ready) begin
			out_valid_q <= seq_res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_ready && seq_res.valid) begin
			out_num_q   <= seq_num;
			out_prime_q <= seq_res.prime;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.tested_number = out_num_q;
	assign out_ch.is_prime      = out_prime_q;

`ifndef SYNTHESIS
	// A prime result is never zero or one
	a_prime_ge_two: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.is_prime |-> out_ch.tested_number > NUM_W'(1))
		else $error("prime flag on zero or one");

	// The only even prime is two
	a_even_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.is_prime && !out_ch.tested_number[0]
		|-> out_ch.tested_number == NUM_W'(FIRST_DIV))
		else $error("even number above two flagged prime");

	// The sequencer leaves idle after taking a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request taken while a test runs");

	// A finished test handed over lands in the result register
	a_res_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		seq_res.valid && seq_res_ready |=> out_valid_q)
		else $error("finished test lost");
`endif

endmodule

`default_nettype wire
